>>> hw/rtl/swrb_pkg.sv
`default_nettype none
package swrb_pkg;

	localparam int unsigned COL_W    = 16;
	localparam int unsigned LINE_W   = 24;
	localparam int unsigned SPAN_W   = 16;
	localparam int unsigned CELL_W   = 24;
	localparam int unsigned BYTE_W   = 32;
	localparam int unsigned REL_W    = 25;
	localparam int unsigned IN_W     = 40;
	localparam int unsigned OUT_W    = 152;
	localparam int unsigned QDEPTH   = 2;
	localparam int unsigned QPTR_W   = 1;
	localparam int unsigned QCNT_W   = 2;

	localparam logic [COL_W-1:0]  COLUMNS_RESET = 16'd80;
	localparam logic [CELL_W-1:0] CELL_MAX      = 24'hFFFFFF;

	// Input word kinds carried on tuser.
	localparam logic CMD_SPAN  = 1'b0;
	localparam logic CMD_EMPTY = 1'b1;

	// Register indexes of the configuration port.
	localparam logic REG_COLUMNS = 1'b0;

	// One finished row as the front part sees it; the end byte is still split
	// into the line start and the line-relative end.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [SPAN_W-1:0] first;
		logic [SPAN_W-1:0] count;
		logic [CELL_W-1:0] start;
		logic [CELL_W-1:0] cells;
		logic [BYTE_W-1:0] base;
		logic [REL_W-1:0]  rel;
	} row_t;

	// What one input word leaves for the back part: one or two rows.
	typedef struct packed {
		logic two;
		logic ovf;
		row_t row_a;
		row_t row_b;
	} entry_t;

	// A row ready for the output channel.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [SPAN_W-1:0] first;
		logic [SPAN_W-1:0] count;
		logic [CELL_W-1:0] start;
		logic [CELL_W-1:0] cells;
		logic [COL_W-1:0]  visible;
		logic [BYTE_W-1:0] end_byte;
		logic              last;
		logic              ovf;
	} res_t;

	function automatic logic [CELL_W-1:0] sat_cells(input logic [CELL_W:0] s);
		sat_cells = s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/swrb_front.sv
`default_nettype none
module swrb_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [swrb_pkg::COL_W-1:0]    columns,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [7:0]                    span_cells,
	input  wire logic [23:0]                   span_offset,
	input  wire logic [7:0]                    span_bytes,
	input  wire logic                          last_in_line,
	input  wire logic                          q_full,
	output logic                               q_push,
	output swrb_pkg::entry_t                   q_entry
);

	logic [swrb_pkg::LINE_W-1:0] line_q;
	logic [swrb_pkg::SPAN_W-1:0] span_pos_q;
	logic [swrb_pkg::SPAN_W-1:0] row_first_q;
	logic [swrb_pkg::SPAN_W-1:0] row_count_q;
	logic [swrb_pkg::CELL_W-1:0] row_start_q;
	logic [swrb_pkg::CELL_W-1:0] row_cells_q;
	logic [swrb_pkg::BYTE_W-1:0] base_q;
	logic [swrb_pkg::BYTE_W-1:0] byte_sum_q;
	logic [swrb_pkg::REL_W-1:0]  last_end_q;
	logic                        ovf_q;
	logic                        open_q;

	logic                        accept;
	logic [swrb_pkg::CELL_W-1:0] used;
	logic [swrb_pkg::COL_W-1:0]  room;
	logic                        brk;
	logic [swrb_pkg::SPAN_W-1:0] cur_first;
	logic [swrb_pkg::SPAN_W-1:0] cur_count;
	logic [swrb_pkg::CELL_W-1:0] cur_start;
	logic [swrb_pkg::CELL_W-1:0] cur_cells_base;
	logic [swrb_pkg::CELL_W-1:0] cur_cells;
	logic [swrb_pkg::REL_W-1:0]  span_end;
	logic [swrb_pkg::BYTE_W:0]   sum_next;
	logic [swrb_pkg::BYTE_W+1:0] base_span;
	logic [swrb_pkg::BYTE_W+1:0] base_one;
	logic [swrb_pkg::BYTE_W+1:0] base_two;
	logic                        span_close_ovf;
	logic                        one_ovf;
	logic                        step_ovf;
	swrb_pkg::row_t              row_old;
	swrb_pkg::row_t              row_cur;
	swrb_pkg::row_t              row_empty;
	swrb_pkg::row_t              row_empty_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		used = (row_cells_q < {8'd0, columns}) ? row_cells_q : {8'd0, columns};
		room = columns - used[swrb_pkg::COL_W-1:0];
		brk  = (span_cells != 8'd0) && (row_cells_q != '0) && ({8'd0, span_cells} > room);

		cur_first      = brk ? span_pos_q : row_first_q;
		cur_count      = (brk ? '0 : row_count_q) + 16'd1;
		cur_start      = brk ? swrb_pkg::sat_cells({1'b0, row_start_q} + {1'b0, row_cells_q})
		                     : row_start_q;
		cur_cells_base = brk ? '0 : row_cells_q;
		cur_cells      = swrb_pkg::sat_cells({1'b0, cur_cells_base} + {17'd0, span_cells});
		span_end       = {1'b0, span_offset} + {17'd0, span_bytes};
		sum_next       = {1'b0, byte_sum_q} + {25'd0, span_bytes};

		// The next line start is base + (byte sum truncated to 32 bits) + 1. The
		// three operands are added at full width and the lost carry of the byte
		// sum is taken back out when judging overflow.
		base_span = {2'b00, base_q} + {2'b00, byte_sum_q} + {26'd0, span_bytes} + 34'd1;
		base_one  = {2'b00, base_q} + {2'b00, byte_sum_q} + 34'd1;
		base_two  = {2'b00, base_q} + {2'b00, byte_sum_q} + 34'd2;
		span_close_ovf = sum_next[swrb_pkg::BYTE_W] ? base_span[swrb_pkg::BYTE_W+1]
		                                            : (|base_span[swrb_pkg::BYTE_W+1 -: 2]);
		one_ovf = |base_one[swrb_pkg::BYTE_W+1 -: 2];

		row_old = '{line: line_q, first: row_first_q, count: row_count_q, start: row_start_q,
		            cells: row_cells_q, base: base_q, rel: last_end_q};
		row_cur = '{line: line_q, first: cur_first, count: cur_count, start: cur_start,
		            cells: cur_cells, base: base_q, rel: span_end};
		row_empty = '{line: line_q, first: '0, count: '0, start: '0, cells: '0,
		              base: base_q, rel: '0};
		row_empty_next = '{line: line_q + 24'd1, first: '0, count: '0, start: '0, cells: '0,
		                   base: base_one[swrb_pkg::BYTE_W-1:0], rel: '0};

		q_entry = '{two: 1'b0, ovf: 1'b0, row_a: row_cur, row_b: row_cur};
		q_push  = 1'b0;
		if (cmd == swrb_pkg::CMD_EMPTY) begin
			q_push = accept;
			if (open_q) begin
				// A pending line is closed first, then the empty line follows it.
				q_entry.two   = 1'b1;
				q_entry.row_a = row_old;
				q_entry.row_b = row_empty_next;
				step_ovf = one_ovf || (base_one[swrb_pkg::BYTE_W-1:0] == '1);
			end else begin
				q_entry.row_a = row_empty;
				step_ovf = one_ovf;
			end
		end else begin
			q_push = accept && (brk || last_in_line);
			if (brk) begin
				q_entry.row_a = row_old;
				q_entry.two   = last_in_line;
			end
			step_ovf = sum_next[swrb_pkg::BYTE_W] || (last_in_line && span_close_ovf);
		end
		q_entry.ovf = ovf_q || step_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= '0;
			span_pos_q  <= '0;
			row_first_q <= '0;
			row_count_q <= '0;
			row_start_q <= '0;
			row_cells_q <= '0;
			base_q      <= '0;
			byte_sum_q  <= '0;
			last_end_q  <= '0;
			ovf_q       <= 1'b0;
			open_q      <= 1'b0;
		end else if (accept) begin
			ovf_q <= ovf_q || step_ovf;
			if (cmd == swrb_pkg::CMD_EMPTY || last_in_line) begin
				// Closing a line clears all row state.
				span_pos_q  <= '0;
				row_first_q <= '0;
				row_count_q <= '0;
				row_start_q <= '0;
				row_cells_q <= '0;
				byte_sum_q  <= '0;
				last_end_q  <= '0;
				open_q      <= 1'b0;
				if (cmd == swrb_pkg::CMD_EMPTY) begin
					line_q <= line_q + (open_q ? 24'd2 : 24'd1);
					base_q <= open_q ? base_two[swrb_pkg::BYTE_W-1:0]
					                 : base_one[swrb_pkg::BYTE_W-1:0];
				end else begin
					line_q <= line_q + 24'd1;
					base_q <= base_span[swrb_pkg::BYTE_W-1:0];
				end
			end else begin
				span_pos_q  <= span_pos_q + 16'd1;
				row_first_q <= cur_first;
				row_count_q <= cur_count;
				row_start_q <= cur_start;
				row_cells_q <= cur_cells;
				byte_sum_q  <= sum_next[swrb_pkg::BYTE_W-1:0];
				last_end_q  <= span_end;
				open_q      <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/swrb_queue.sv
`default_nettype none
module swrb_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire swrb_pkg::entry_t  din,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output swrb_pkg::entry_t       dout
);

	swrb_pkg::entry_t            mem_q [swrb_pkg::QDEPTH];
	logic [swrb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [swrb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [swrb_pkg::QCNT_W-1:0] count_q;

	assign full  = (count_q == swrb_pkg::QCNT_W'(swrb_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + swrb_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - swrb_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/swrb_back.sv
`default_nettype none
module swrb_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [swrb_pkg::COL_W-1:0]  columns,
	input  wire logic                        q_valid,
	input  wire swrb_pkg::entry_t            q_entry,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output swrb_pkg::res_t                   out_res
);

	logic           out_valid_q;
	swrb_pkg::res_t out_q;
	logic           pend_valid_q;
	swrb_pkg::res_t pend_q;
	logic           ovf_q;

	logic [swrb_pkg::BYTE_W:0] end_a;
	logic [swrb_pkg::BYTE_W:0] end_b;
	logic                      carry;
	logic                      row_ovf;
	logic                      slot_free;
	swrb_pkg::res_t            res_a;
	swrb_pkg::res_t            res_b;

	function automatic logic [swrb_pkg::COL_W-1:0] clip(
		input logic [swrb_pkg::CELL_W-1:0] cells,
		input logic [swrb_pkg::COL_W-1:0]  cols
	);
		clip = (cells < {8'd0, cols}) ? cells[swrb_pkg::COL_W-1:0] : cols;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = q_valid && !pend_valid_q && slot_free;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_comb begin
		end_a = {1'b0, q_entry.row_a.base} + {8'd0, q_entry.row_a.rel};
		end_b = {1'b0, q_entry.row_b.base} + {8'd0, q_entry.row_b.rel};
		carry = end_a[swrb_pkg::BYTE_W] || (q_entry.two && end_b[swrb_pkg::BYTE_W]);
		// Every row of one input word carries the flag as it stands after the word.
		row_ovf = q_entry.ovf || ovf_q || carry;
		res_a = '{line: q_entry.row_a.line, first: q_entry.row_a.first,
		          count: q_entry.row_a.count, start: q_entry.row_a.start,
		          cells: q_entry.row_a.cells, visible: clip(q_entry.row_a.cells, columns),
		          end_byte: end_a[swrb_pkg::BYTE_W-1:0], last: !q_entry.two, ovf: row_ovf};
		res_b = '{line: q_entry.row_b.line, first: q_entry.row_b.first,
		          count: q_entry.row_b.count, start: q_entry.row_b.start,
		          cells: q_entry.row_b.cells, visible: clip(q_entry.row_b.cells, columns),
		          end_byte: end_b[swrb_pkg::BYTE_W-1:0], last: 1'b1, ovf: row_ovf};
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res_a;
			if (q_entry.two) begin
				pend_q <= res_b;
			end
		end else if (pend_valid_q && slot_free) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= q_entry.two;
				ovf_q        <= ovf_q || carry;
			end else if (pend_valid_q && slot_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/soft_wrap_row_builder.sv
// Soft-wrap row builder.
// Input words arrive on the s_ stream: tuser selects a text span or an empty
// line, tlast marks the span that ends its logical line. Spans are packed
// greedily into rows of "columns" cells; each finished row leaves on the m_
// stream with its placement and document-absolute end byte. m_tlast marks the
// last row caused by one input word, m_tuser is the sticky overflow flag.
// The columns register sits at byte address 0 of the APB port; write it only
// while the block is idle. Reset sets it to 80 and clears all line state.
// Throughput: one input word per cycle while s_tready is high. A word that
// yields two rows holds the output register for both rows in turn, so the row
// rate is the limit: one row per cycle on the output side while m_tready is
// high. The front part updates its running line state once per accepted word.
// Path: with nothing ahead of it, the first row of a word is written into the
// queue when the word is accepted and is then registered in the output stage.
// When the receiver stalls, a two-entry queue and the output stage keep
// taking words until the queue fills; s_tready then drops.
`default_nettype none
module soft_wrap_row_builder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// span_cells[7:0], span_offset[31:8], span_bytes[39:32]
	input  wire logic [swrb_pkg::IN_W-1:0]    s_tdata,
	// cmd
	input  wire logic                         s_tuser,
	input  wire logic                         s_tlast,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// line_index[23:0], lead_span[39:24], span_total[55:40], start_cell[79:56],
	// filled_cells[103:80], visible_cells[119:104], end_byte[151:120]
	output logic [swrb_pkg::OUT_W-1:0]        m_tdata,
	// overflow
	output logic                              m_tuser,
	output logic                              m_tlast
);

	logic [swrb_pkg::COL_W-1:0] columns_q;
	logic                       q_full;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_valid;
	swrb_pkg::entry_t           push_entry;
	swrb_pkg::entry_t           head_entry;
	swrb_pkg::res_t             res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == swrb_pkg::REG_COLUMNS) ? {16'd0, columns_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= swrb_pkg::COLUMNS_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == swrb_pkg::REG_COLUMNS) begin
			columns_q <= pwdata[swrb_pkg::COL_W-1:0];
		end
	end

	swrb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.columns      (columns_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.cmd          (s_tuser),
		.span_cells   (s_tdata[7:0]),
		.span_offset  (s_tdata[31:8]),
		.span_bytes   (s_tdata[39:32]),
		.last_in_line (s_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (push_entry)
	);

	swrb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_entry),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (head_entry)
	);

	swrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.columns   (columns_q),
		.q_valid   (q_valid),
		.q_entry   (head_entry),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.end_byte, res.visible, res.cells, res.start, res.count,
	                  res.first, res.line};
	assign m_tlast = res.last;
	assign m_tuser = res.ovf;

endmodule
`default_nettype wire

>>> hw/rtl/swrb_checker.sv
`default_nettype none
module swrb_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [151:0] m_tdata,
	input  wire logic         m_tuser,
	input  wire logic         m_tlast
);

	logic ovf_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tuser) begin
			ovf_seen_q <= 1'b1;
		end
	end

	// Protocol: a stalled word stays and holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// Once overflow has been reported it stays reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ovf_seen_q |-> m_tuser)
		else $error("overflow flag cleared after being set");

	// Visible cells never exceed content cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {8'd0, m_tdata[119:104]} <= m_tdata[103:80])
		else $error("visible cells exceed content cells");

	// A row without spans is an empty line: no cells and no span index.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[55:40] == 16'd0 |->
			m_tdata[103:80] == 24'd0 && m_tdata[79:56] == 24'd0 && m_tdata[39:24] == 16'd0)
		else $error("empty row carries cells");

endmodule

bind soft_wrap_row_builder swrb_checker u_swrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
